>>> rtl/dstf_pkg.sv
// Shared types, constants and shade ramp for the depth shaded triangle fill.
// No dependencies; used by every other file of the block.
package dstf_pkg;

  localparam int CW        = 12;
  localparam int ZW        = 16;
  localparam int EW        = 28;
  localparam int MAW       = 18;
  localparam int MACW      = 48;
  localparam int MDW       = 44;
  localparam int DIV_STEPS = 7;
  localparam int NUMW      = MDW + DIV_STEPS;
  localparam int SHADE_W   = 7;
  localparam int PAINT_W   = 4;
  localparam int SHADE_TOP = 70;
  localparam int RAMP_LEN  = 71;
  localparam int NEAR_RAW  = 40;
  localparam logic [15:0] MAX_DEPTH_RST = 16'd12288;
  localparam logic [6:0]  CHAR_BLANK    = 7'd32;
  localparam logic [6:0]  SHADE_DUP     = 7'd29;
  localparam logic [6:0]  RANK_DUP      = 7'd3;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [11:0] vertex_a_x;
    logic signed [11:0] vertex_a_y;
    logic [15:0]        vertex_a_z;
    logic signed [11:0] vertex_b_x;
    logic signed [11:0] vertex_b_y;
    logic [15:0]        vertex_b_z;
    logic signed [11:0] vertex_c_x;
    logic signed [11:0] vertex_c_y;
    logic [15:0]        vertex_c_z;
    logic [3:0]         paint_color;
    logic [14:0]        pixel_addr;
  } in_t;

  typedef struct packed {
    logic       triangle_drawn;
    logic [6:0] pixel_shade;
    logic [6:0] pixel_char;
    logic [3:0] pixel_paint;
  } out_t;

  typedef struct packed {
    logic vld;
    logic clr;
    logic neg;
  } mac_op_t;

  localparam logic [6:0] RAMP [RAMP_LEN] = '{
    7'd32,  7'd46,  7'd39,  7'd92,  7'd96,  7'd94,  7'd34,  7'd44,  7'd58,  7'd59,
    7'd73,  7'd108, 7'd33,  7'd105, 7'd62,  7'd60,  7'd126, 7'd43,  7'd95,  7'd45,
    7'd63,  7'd93,  7'd91,  7'd125, 7'd123, 7'd49,  7'd41,  7'd40,  7'd124, 7'd92,
    7'd47,  7'd116, 7'd102, 7'd106, 7'd114, 7'd120, 7'd110, 7'd117, 7'd118, 7'd99,
    7'd122, 7'd88,  7'd89,  7'd85,  7'd74,  7'd67,  7'd76,  7'd81,  7'd48,  7'd79,
    7'd90,  7'd109, 7'd119, 7'd113, 7'd112, 7'd100, 7'd98,  7'd107, 7'd104, 7'd97,
    7'd111, 7'd42,  7'd35,  7'd77,  7'd87,  7'd38,  7'd56,  7'd37,  7'd66,  7'd64,
    7'd36
  };

  function automatic logic [6:0] ramp_char(input logic [6:0] s);
    if (s > 7'(SHADE_TOP)) return CHAR_BLANK;
    return RAMP[s];
  endfunction

  // backslash appears twice on the ramp; the second one ranks as the first
  function automatic logic [6:0] shade_rank(input logic [6:0] s);
    return (s == SHADE_DUP) ? RANK_DUP : s;
  endfunction

  function automatic out_t blank_res(input logic drawn);
    out_t r;
    r.triangle_drawn = drawn;
    r.pixel_shade    = '0;
    r.pixel_char     = CHAR_BLANK;
    r.pixel_paint    = '0;
    return r;
  endfunction

endpackage

>>> rtl/dstf_mac.sv
// Shared signed multiply-accumulate unit: registered product, then accumulate.
// Depends on dstf_pkg for widths and the op struct.
module dstf_mac (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dstf_pkg::mac_op_t              op,
  input  logic signed [dstf_pkg::MAW-1:0] a,
  input  logic signed [dstf_pkg::EW-1:0]  b,
  output logic signed [dstf_pkg::MACW-1:0] acc
);

  localparam int PW = dstf_pkg::MAW + dstf_pkg::EW;

  logic signed [PW-1:0]             prod_r;
  dstf_pkg::mac_op_t                op_r;
  logic signed [dstf_pkg::MACW-1:0] acc_r;
  logic signed [dstf_pkg::MACW-1:0] term;

  assign term = op_r.neg ? -dstf_pkg::MACW'(prod_r) : dstf_pkg::MACW'(prod_r);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (!rst_n) begin
      op_r <= '0;
    end else begin
      op_r <= op;
    end
    if (op_r.vld) begin
      acc_r <= op_r.clr ? term : acc_r + term;
    end
  end

  assign acc = acc_r;

endmodule

>>> rtl/dstf_div.sv
// Restoring divider, one quotient bit per cycle, for the shade quotient.
// Depends on dstf_pkg for operand widths and step count.
module dstf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dstf_pkg::NUMW-1:0] num,
  input  logic [dstf_pkg::MDW-1:0]  den,
  output logic                      done,
  output logic [dstf_pkg::SHADE_W-1:0] quo
);

  localparam int NW = dstf_pkg::NUMW;
  localparam logic [2:0] STEPS = 3'(dstf_pkg::DIV_STEPS);

  logic [NW-1:0]  rem_r, rem_nxt;
  logic [NW-1:0]  sub_r, sub_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [dstf_pkg::SHADE_W-1:0] q_r, q_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    sub_nxt  = sub_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      sub_nxt  = NW'(den) << (dstf_pkg::DIV_STEPS - 1);
      cnt_nxt  = STEPS;
      busy_nxt = 1'b1;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (rem_r >= sub_r) begin
        rem_nxt = rem_r - sub_r;
        q_nxt   = {q_r[dstf_pkg::SHADE_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[dstf_pkg::SHADE_W-2:0], 1'b0};
      end
      sub_nxt = sub_r >> 1;
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sub_r <= sub_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

>>> rtl/dstf_store.sv
// Frame store: shade and paint memories, one write and one registered read port.
// Depends on dstf_pkg for the field widths.
module dstf_store #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [dstf_pkg::SHADE_W-1:0] rd_shade,
  output logic [dstf_pkg::PAINT_W-1:0] rd_paint,
  input  logic                         wr_shade_en,
  input  logic                         wr_paint_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [dstf_pkg::SHADE_W-1:0] wr_shade,
  input  logic [dstf_pkg::PAINT_W-1:0] wr_paint
);

  logic [dstf_pkg::SHADE_W-1:0] shade_mem [DEPTH];
  logic [dstf_pkg::PAINT_W-1:0] paint_mem [DEPTH];
  logic [dstf_pkg::SHADE_W-1:0] rd_shade_r;
  logic [dstf_pkg::PAINT_W-1:0] rd_paint_r;

  always_ff @(posedge clk) begin
    if (wr_shade_en) begin
      shade_mem[wr_addr] <= wr_shade;
    end
    if (rd_en) begin
      rd_shade_r <= shade_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_paint_en) begin
      paint_mem[wr_addr] <= wr_paint;
    end
    if (rd_en) begin
      rd_paint_r <= paint_mem[rd_addr];
    end
  end

  assign rd_shade = rd_shade_r;
  assign rd_paint = rd_paint_r;

endmodule

>>> rtl/depth_shaded_triangle_fill.sv
// Top level: command sequencer, triangle setup, box scan and pixel update.
// Depends on dstf_pkg, dstf_mac, dstf_div and dstf_store.
//
//   channel  direction  handshake          beat
//   in_      in         in_valid/in_stall  dstf_pkg::in_t command
//   out_     out        out_valid/out_stall dstf_pkg::out_t result, one per command
//   cfg_     in         cfg_we             cfg_wdata = max_depth
//
// After reset a clearing pass zeroes both memories.
// Clear: one shade memory entry is zeroed per cycle; the paint memory is kept.
// Draw: setup through the shared multiplier, then a scan of the box; a covered pixel
// takes 3 multiplies and, unless at or beyond max depth, 7 divider steps and a memory update.
// A result waits in the output register; the next command is taken meanwhile.
module depth_shaded_triangle_fill #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dstf_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dstf_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = dstf_pkg::EW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [12:0] X_LIM = 13'(FRAME_WIDTH - 1);
  localparam logic signed [12:0] Y_LIM = 13'(FRAME_HEIGHT);
  localparam logic signed [12:0] ONE13 = 13'sd1;

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_READ  = 10'b0000000100,
    S_CLEAR = 10'b0000001000,
    S_SETUP = 10'b0000010000,
    S_SCAN  = 10'b0000100000,
    S_PIX   = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_WRITE = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  function automatic logic signed [12:0] sx13(input logic signed [11:0] v);
    return {v[11], v};
  endfunction

  function automatic logic signed [13:0] sub14(input logic signed [12:0] p,
                                               input logic signed [12:0] q);
    return {p[12], p} - {q[12], q};
  endfunction

  function automatic logic signed [dstf_pkg::MAW-1:0] sxa(input logic signed [12:0] v);
    return {{(dstf_pkg::MAW-13){v[12]}}, v};
  endfunction

  function automatic logic signed [EW-1:0] sxb(input logic signed [13:0] v);
    return {{(EW-14){v[13]}}, v};
  endfunction

  function automatic logic signed [EW-1:0] sxe(input logic signed [12:0] v);
    return {{(EW-13){v[12]}}, v};
  endfunction

  function automatic logic [EW-1:0] abs_e(input logic signed [EW-1:0] v);
    return v[EW-1] ? EW'(-v) : EW'(v);
  endfunction

  function automatic logic signed [12:0] min3(input logic signed [12:0] a,
                                              input logic signed [12:0] b,
                                              input logic signed [12:0] c);
    logic signed [12:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [12:0] max3(input logic signed [12:0] a,
                                              input logic signed [12:0] b,
                                              input logic signed [12:0] c);
    logic signed [12:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [15:0] max_depth_r, max_depth_nxt;
  dstf_pkg::in_t tri_r, tri_nxt;
  logic signed [12:0] x0_r, x0_nxt, x1_r, x1_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic signed [12:0] x_r, x_nxt, y_r, y_nxt;
  logic [3:0] sstep_r, sstep_nxt;
  logic [2:0] pstep_r, pstep_nxt;
  logic [EW-1:0] total_r, total_nxt;
  logic [dstf_pkg::MDW-1:0] md_r, md_nxt;
  logic signed [EW-1:0] e_ab_r, e_ab_nxt, e_bc_r, e_bc_nxt, e_ca_r, e_ca_nxt;
  logic signed [EW-1:0] r_ab_r, r_ab_nxt, r_bc_r, r_bc_nxt, r_ca_r, r_ca_nxt;
  logic [EW-1:0] ab_r, ab_nxt, bc_r, bc_nxt, ca_r, ca_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [6:0] shade_r, shade_nxt;
  dstf_pkg::out_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  dstf_pkg::out_t out_data_r, out_data_nxt;

  dstf_pkg::mac_op_t mac_op;
  logic signed [dstf_pkg::MAW-1:0] mac_a;
  logic signed [EW-1:0] mac_b;
  logic signed [dstf_pkg::MACW-1:0] mac_acc;

  logic div_start, div_done;
  logic [dstf_pkg::NUMW-1:0] div_num;
  logic [6:0] div_q;

  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic [6:0] rd_shade;
  logic [3:0] rd_paint;
  logic wr_shade_en, wr_paint_en;
  logic [AW-1:0] wr_addr;
  logic [6:0] wr_shade;
  logic [3:0] wr_paint;

  logic in_accept;
  logic signed [12:0] ax, ay, bx, by, cx, cy;
  logic signed [12:0] dx_ab, dy_ab, dx_bc, dy_bc, dx_ca, dy_ca;
  logic signed [12:0] ix_min, ix_max, iy_min, iy_max;
  logic depth_pass;

  logic [EW-1:0] ab_abs, bc_abs, ca_abs;
  logic pix_in;
  logic last_col, adv_done;
  logic signed [12:0] ax_nxt, ay_nxt;
  logic signed [EW-1:0] ae_ab, ae_bc, ae_ca, ar_ab, ar_bc, ar_ca;
  logic [dstf_pkg::MDW-1:0] diff;
  logic num_ge;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign ax = sx13(tri_r.vertex_a_x);
  assign ay = sx13(tri_r.vertex_a_y);
  assign bx = sx13(tri_r.vertex_b_x);
  assign by = sx13(tri_r.vertex_b_y);
  assign cx = sx13(tri_r.vertex_c_x);
  assign cy = sx13(tri_r.vertex_c_y);
  assign dx_ab = bx - ax;
  assign dy_ab = by - ay;
  assign dx_bc = cx - bx;
  assign dy_bc = cy - by;
  assign dx_ca = ax - cx;
  assign dy_ca = ay - cy;

  assign ix_min = min3(sx13(in_data.vertex_a_x), sx13(in_data.vertex_b_x),
                       sx13(in_data.vertex_c_x)) - ONE13;
  assign ix_max = max3(sx13(in_data.vertex_a_x), sx13(in_data.vertex_b_x),
                       sx13(in_data.vertex_c_x));
  assign iy_min = min3(sx13(in_data.vertex_a_y), sx13(in_data.vertex_b_y),
                       sx13(in_data.vertex_c_y));
  assign iy_max = max3(sx13(in_data.vertex_a_y), sx13(in_data.vertex_b_y),
                       sx13(in_data.vertex_c_y));

  assign depth_pass =
      (in_data.vertex_a_z > 16'(dstf_pkg::NEAR_RAW)) && (in_data.vertex_a_z < max_depth_r) &&
      (in_data.vertex_b_z > 16'(dstf_pkg::NEAR_RAW)) && (in_data.vertex_b_z < max_depth_r) &&
      (in_data.vertex_c_z > 16'(dstf_pkg::NEAR_RAW)) && (in_data.vertex_c_z < max_depth_r);

  // edge values stay signed; the areas are their magnitudes
  assign ab_abs = abs_e(e_ab_r);
  assign bc_abs = abs_e(e_bc_r);
  assign ca_abs = abs_e(e_ca_r);
  assign pix_in = ((EW + 2)'(ab_abs) + (EW + 2)'(bc_abs) + (EW + 2)'(ca_abs))
                  == (EW + 2)'(total_r);

  // scan advance: next column, or wrap to the next row
  assign last_col = (x_r == x1_r);
  assign adv_done = last_col && ((y_r + ONE13) == y1_r);
  always_comb begin
    if (last_col) begin
      ax_nxt = x0_r;
      ay_nxt = y_r + ONE13;
      ar_ab  = r_ab_r + sxe(dx_ab);
      ar_bc  = r_bc_r + sxe(dx_bc);
      ar_ca  = r_ca_r + sxe(dx_ca);
      ae_ab  = ar_ab;
      ae_bc  = ar_bc;
      ae_ca  = ar_ca;
    end else begin
      ax_nxt = x_r + ONE13;
      ay_nxt = y_r;
      ar_ab  = r_ab_r;
      ar_bc  = r_bc_r;
      ar_ca  = r_ca_r;
      ae_ab  = e_ab_r - sxe(dy_ab);
      ae_bc  = e_bc_r - sxe(dy_bc);
      ae_ca  = e_ca_r - sxe(dy_ca);
    end
  end

  assign num_ge  = $unsigned(mac_acc) >= dstf_pkg::MACW'(md_r);
  assign diff    = md_r - mac_acc[dstf_pkg::MDW-1:0];
  assign div_num = (dstf_pkg::NUMW'(diff) << 6) + (dstf_pkg::NUMW'(diff) << 2)
                 + (dstf_pkg::NUMW'(diff) << 1);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    max_depth_nxt = cfg_we ? cfg_wdata : max_depth_r;
    tri_nxt       = tri_r;
    x0_nxt = x0_r;  x1_nxt = x1_r;  y0_nxt = y0_r;  y1_nxt = y1_r;
    x_nxt  = x_r;   y_nxt  = y_r;
    sstep_nxt = sstep_r;
    pstep_nxt = pstep_r;
    total_nxt = total_r;
    md_nxt    = md_r;
    e_ab_nxt = e_ab_r;  e_bc_nxt = e_bc_r;  e_ca_nxt = e_ca_r;
    r_ab_nxt = r_ab_r;  r_bc_nxt = r_bc_r;  r_ca_nxt = r_ca_r;
    ab_nxt = ab_r;  bc_nxt = bc_r;  ca_nxt = ca_r;
    addr_nxt  = addr_r;
    shade_nxt = shade_r;
    res_nxt   = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    mac_op = '0;
    mac_a  = '0;
    mac_b  = '0;
    div_start   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = addr_r;
    wr_shade_en = 1'b0;
    wr_paint_en = 1'b0;
    wr_addr     = addr_r;
    wr_shade    = shade_r;
    wr_paint    = tri_r.paint_color;

    unique case (state_r)
      S_INIT: begin
        wr_shade_en = 1'b1;
        wr_paint_en = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_shade    = '0;
        wr_paint    = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          clr_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          tri_nxt = in_data;
          x0_nxt  = (ix_min < ONE13) ? ONE13 : ix_min;
          x1_nxt  = (ix_max > X_LIM) ? X_LIM : ix_max;
          y0_nxt  = (iy_min < ONE13) ? ONE13 : iy_min;
          y1_nxt  = (iy_max > Y_LIM) ? Y_LIM : iy_max;
          sstep_nxt = '0;
          unique case (in_data.command)
            dstf_pkg::CMD_DRAW: begin
              if (depth_pass) begin
                state_nxt = S_SETUP;
              end else begin
                res_nxt   = dstf_pkg::blank_res(1'b0);
                state_nxt = S_DONE;
              end
            end
            dstf_pkg::CMD_READ: begin
              if (32'(in_data.pixel_addr) < DEPTH) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_data.pixel_addr);
                state_nxt = S_READ;
              end else begin
                res_nxt   = dstf_pkg::blank_res(1'b0);
                state_nxt = S_DONE;
              end
            end
            dstf_pkg::CMD_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            dstf_pkg::CMD_NOP: begin
              res_nxt   = dstf_pkg::blank_res(1'b0);
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        res_nxt.triangle_drawn = 1'b0;
        res_nxt.pixel_shade    = rd_shade;
        res_nxt.pixel_char     = dstf_pkg::ramp_char(rd_shade);
        res_nxt.pixel_paint    = rd_paint;
        state_nxt = S_DONE;
      end
      S_CLEAR: begin
        wr_shade_en = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_shade    = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          clr_cnt_nxt = '0;
          res_nxt     = dstf_pkg::blank_res(1'b0);
          state_nxt   = S_DONE;
        end
      end
      S_SETUP: begin
        sstep_nxt  = sstep_r + 4'd1;
        mac_op.vld = (sstep_r <= 4'd8);
        mac_op.clr = !sstep_r[0];
        mac_op.neg = sstep_r[0];
        unique case (sstep_r)
          4'd0: begin mac_a = sxa(dx_ab); mac_b = sxb(sub14(cy, ay)); end
          4'd1: begin mac_a = sxa(dy_ab); mac_b = sxb(sub14(cx, ax)); end
          4'd2: begin mac_a = sxa(dx_ab); mac_b = sxb(sub14(y0_r, ay)); end
          4'd3: begin mac_a = sxa(dy_ab); mac_b = sxb(sub14(x0_r, ax)); end
          4'd4: begin mac_a = sxa(dx_bc); mac_b = sxb(sub14(y0_r, by)); end
          4'd5: begin mac_a = sxa(dy_bc); mac_b = sxb(sub14(x0_r, bx)); end
          4'd6: begin mac_a = sxa(dx_ca); mac_b = sxb(sub14(y0_r, cy)); end
          4'd7: begin mac_a = sxa(dy_ca); mac_b = sxb(sub14(x0_r, cx)); end
          4'd8: begin
            mac_a = {2'b00, max_depth_r};
            mac_b = total_r;
          end
          default: begin
            mac_a = '0;
            mac_b = '0;
          end
        endcase
        if (sstep_r == 4'd3) total_nxt = abs_e($signed(mac_acc[EW-1:0]));
        if (sstep_r == 4'd5) begin
          e_ab_nxt = mac_acc[EW-1:0];
          r_ab_nxt = mac_acc[EW-1:0];
        end
        if (sstep_r == 4'd7) begin
          e_bc_nxt = mac_acc[EW-1:0];
          r_bc_nxt = mac_acc[EW-1:0];
        end
        if (sstep_r == 4'd9) begin
          e_ca_nxt = mac_acc[EW-1:0];
          r_ca_nxt = mac_acc[EW-1:0];
        end
        if (sstep_r == 4'd10) begin
          md_nxt = mac_acc[dstf_pkg::MDW-1:0];
          x_nxt  = x0_r;
          y_nxt  = y0_r;
          if ((total_r == '0) || (y0_r >= y1_r) || (x0_r > x1_r)) begin
            res_nxt   = dstf_pkg::blank_res(1'b1);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pix_in) begin
          ab_nxt    = ab_abs;
          bc_nxt    = bc_abs;
          ca_nxt    = ca_abs;
          addr_nxt  = AW'(32'($unsigned(y_r)) * FRAME_WIDTH + 32'($unsigned(x_r)));
          pstep_nxt = '0;
          state_nxt = S_PIX;
        end else begin
          x_nxt = ax_nxt;  y_nxt = ay_nxt;
          e_ab_nxt = ae_ab;  e_bc_nxt = ae_bc;  e_ca_nxt = ae_ca;
          r_ab_nxt = ar_ab;  r_bc_nxt = ar_bc;  r_ca_nxt = ar_ca;
          if (adv_done) begin
            res_nxt   = dstf_pkg::blank_res(1'b1);
            state_nxt = S_DONE;
          end
        end
      end
      S_PIX: begin
        pstep_nxt = pstep_r + 3'd1;
        mac_op.vld = (pstep_r <= 3'd2);
        mac_op.clr = (pstep_r == 3'd0);
        unique case (pstep_r)
          3'd0: begin
            mac_a = {2'b00, tri_r.vertex_a_z};
            mac_b = bc_r;
            rd_en = 1'b1;
          end
          3'd1: begin mac_a = {2'b00, tri_r.vertex_b_z}; mac_b = ca_r; end
          3'd2: begin mac_a = {2'b00, tri_r.vertex_c_z}; mac_b = ab_r; end
          default: begin
            mac_a = '0;
            mac_b = '0;
          end
        endcase
        if (pstep_r == 3'd4) begin
          if (num_ge) begin
            x_nxt = ax_nxt;  y_nxt = ay_nxt;
            e_ab_nxt = ae_ab;  e_bc_nxt = ae_bc;  e_ca_nxt = ae_ca;
            r_ab_nxt = ar_ab;  r_bc_nxt = ar_bc;  r_ca_nxt = ar_ca;
            if (adv_done) begin
              res_nxt   = dstf_pkg::blank_res(1'b1);
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          shade_nxt = div_q;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (dstf_pkg::shade_rank(rd_shade) < dstf_pkg::shade_rank(shade_r)) begin
          wr_shade_en = 1'b1;
          wr_paint_en = 1'b1;
        end
        x_nxt = ax_nxt;  y_nxt = ay_nxt;
        e_ab_nxt = ae_ab;  e_bc_nxt = ae_bc;  e_ca_nxt = ae_ca;
        r_ab_nxt = ar_ab;  r_bc_nxt = ar_bc;  r_ca_nxt = ar_ca;
        if (adv_done) begin
          res_nxt   = dstf_pkg::blank_res(1'b1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_cnt_r   <= '0;
      max_depth_r <= dstf_pkg::MAX_DEPTH_RST;
      out_valid_r <= 1'b0;
      sstep_r     <= '0;
      pstep_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      max_depth_r <= max_depth_nxt;
      out_valid_r <= out_valid_nxt;
      sstep_r     <= sstep_nxt;
      pstep_r     <= pstep_nxt;
    end
    tri_r <= tri_nxt;
    x0_r <= x0_nxt;  x1_r <= x1_nxt;  y0_r <= y0_nxt;  y1_r <= y1_nxt;
    x_r  <= x_nxt;   y_r  <= y_nxt;
    total_r <= total_nxt;
    md_r    <= md_nxt;
    e_ab_r <= e_ab_nxt;  e_bc_r <= e_bc_nxt;  e_ca_r <= e_ca_nxt;
    r_ab_r <= r_ab_nxt;  r_bc_r <= r_bc_nxt;  r_ca_r <= r_ca_nxt;
    ab_r <= ab_nxt;  bc_r <= bc_nxt;  ca_r <= ca_nxt;
    addr_r     <= addr_nxt;
    shade_r    <= shade_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dstf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (mac_acc)
  );

  dstf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (md_r),
    .done  (div_done),
    .quo   (div_q)
  );

  dstf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk         (clk),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_shade    (rd_shade),
    .rd_paint    (rd_paint),
    .wr_shade_en (wr_shade_en),
    .wr_paint_en (wr_paint_en),
    .wr_addr     (wr_addr),
    .wr_shade    (wr_shade),
    .wr_paint    (wr_paint)
  );

  a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> in_stall)
    else $error("input beat taken during clearing pass");

  a_write_outranks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && wr_shade_en) |->
      (dstf_pkg::shade_rank(wr_shade) > dstf_pkg::shade_rank(rd_shade)))
    else $error("pixel written without outranking stored shade");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

endmodule
